// ===== hw/rtl/olt_pkg.sv =====
// ----------------------------------------------------------------------------
// Object lifecycle table package
// Beat types, action, result and entry state codes shared across the block.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam logic [2:0] ACT_OBSERVE = 3'd0;
  localparam logic [2:0] ACT_BIND    = 3'd1;
  localparam logic [2:0] ACT_MOVE    = 3'd2;
  localparam logic [2:0] ACT_SWEEP   = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  localparam logic [3:0] CODE_INVALID   = 4'd0;
  localparam logic [3:0] CODE_IGNORED   = 4'd1;
  localparam logic [3:0] CODE_FULL      = 4'd2;
  localparam logic [3:0] CODE_QUEUED    = 4'd3;
  localparam logic [3:0] CODE_DUPLICATE = 4'd4;
  localparam logic [3:0] CODE_ACCEPTED  = 4'd5;
  localparam logic [3:0] CODE_REFUSED   = 4'd6;
  localparam logic [3:0] CODE_NOT_FOUND = 4'd7;
  localparam logic [3:0] CODE_EXPIRED   = 4'd8;
  localparam logic [3:0] CODE_NONE_EXP  = 4'd9;

  localparam logic [2:0] ST_EVQ     = 3'd0;
  localparam logic [2:0] ST_EVPROC  = 3'd1;
  localparam logic [2:0] ST_OCRQ    = 3'd2;
  localparam logic [2:0] ST_OCRPROC = 3'd3;
  localparam logic [2:0] ST_FINAL   = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;
  localparam logic [2:0] ST_FAILED  = 3'd6;
  localparam logic [2:0] ST_DUP     = 3'd7;

  localparam logic CFG_TTL      = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  typedef struct packed {
    logic        [2:0]  action;
    logic        [63:0] object_key;
    logic        [2:0]  target_state;
    logic signed [47:0] event_id_in;
    logic        [47:0] time_ms;
    logic               is_plate;
    logic               fields_complete;
  } in_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [2:0]  entry_state;
    logic        entry_found;
    logic [46:0] bound_event_id;
    logic        event_bound;
    logic [31:0] dup_count;
    logic [6:0]  tracked_count;
    logic        new_object;
    logic [63:0] expired_key;
    logic        last;
  } out_t;

endpackage

// ===== hw/rtl/object_lifecycle_table_with_ttl.sv =====
// ----------------------------------------------------------------------------
// Object lifecycle table with time-to-live
// Every entry record lives in one memory and is scanned one slot a cycle.
// ----------------------------------------------------------------------------
// Observe, bind, move, query and sweep each walk the whole record memory one
// slot per cycle (purging, looking up the key, finding the lowest free slot or
// expiring) before the result is loaded; a sweep then reports expired entries
// in slot order, one result beat each. Ignored or invalid observes and unknown
// actions still take the scan. Valid bits sit in flip-flops and clear at reset;
// no clearing pass is needed.
module object_lifecycle_table_with_ttl #(
  parameter int TABLE_ENTRIES = 64,
  parameter int TIME_BITS     = 48,
  parameter int KEY_BITS      = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  olt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output olt_pkg::out_t out_data,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNTW = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [2:0]           state;
    logic [TIME_BITS-1:0] first_seen;
    logic [TIME_BITS-1:0] last_upd;
    logic [46:0]          eid;
    logic                 bound;
    logic [31:0]          dups;
  } rec_t;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_ACT, S_SEEK, S_FETCH} fsm_t;

  fsm_t                 st;
  olt_pkg::in_t         req;
  logic [IDXW:0]        cnt;
  logic                 pv;
  logic [IDXW-1:0]      pidx;
  logic [TABLE_ENTRIES-1:0] vbits;
  logic [TABLE_ENTRIES-1:0] hitmask;
  logic [CNTW-1:0]      count;
  logic                 found;
  logic [IDXW-1:0]      fslot;
  rec_t                 frec;
  logic                 free_found;
  logic [IDXW-1:0]      free_slot;
  logic [31:0]          ttl;
  logic [6:0]           cap;

  logic                 we;
  logic [IDXW-1:0]      waddr;
  rec_t                 wdata;
  rec_t                 rdata;
  logic [IDXW-1:0]      raddr;

  olt_rec_mem #(
    .DEPTH(TABLE_ENTRIES),
    .AW   (IDXW),
    .W    ($bits(rec_t))
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign raddr    = cnt[IDXW-1:0];
  assign in_stall = (st != S_IDLE);

  logic [KEY_BITS-1:0]  key;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] ttl_e;
  logic [7:0]           cap_e;
  logic                 ofree;

  assign key   = KEY_BITS'(64'(req.object_key));
  assign now   = TIME_BITS'(64'(req.time_ms));
  assign ttl_e = TIME_BITS'((ttl == 32'd0) ? 32'd1 : ttl);
  assign ofree = !out_valid || !out_stall;

  always_comb begin
    if (cap == 7'd0) begin
      cap_e = 8'd1;
    end else if (8'(cap) > 8'(TABLE_ENTRIES)) begin
      cap_e = 8'(TABLE_ENTRIES);
    end else begin
      cap_e = 8'(cap);
    end
  end

  // Per-slot decisions during the scan.
  logic [TIME_BITS-1:0] age_lu, age_fs;
  logic old_lu, old_fs, slot_v, terminal, purge_hit, sweep_hit, vpost, key_hit;
  rec_t swept;

  always_comb begin
    slot_v    = pv && vbits[pidx];
    age_lu    = now - rdata.last_upd;
    age_fs    = now - rdata.first_seen;
    old_lu    = (now >= rdata.last_upd) && (age_lu >= ttl_e);
    old_fs    = (now >= rdata.first_seen) && (age_fs >= ttl_e);
    terminal  = (rdata.state == olt_pkg::ST_DONE) || (rdata.state == olt_pkg::ST_FAILED) ||
                (rdata.state == olt_pkg::ST_DUP);
    sweep_hit = (req.action == olt_pkg::ACT_SWEEP) && slot_v &&
                (rdata.state <= olt_pkg::ST_OCRPROC) && old_fs;
    purge_hit = ((req.action == olt_pkg::ACT_SWEEP) ||
                 ((req.action == olt_pkg::ACT_OBSERVE) && req.is_plate &&
                  req.fields_complete && (now != '0))) &&
                slot_v && terminal && old_lu && !sweep_hit;
    vpost     = slot_v && !purge_hit;
    key_hit   = vpost && (rdata.key == key);
    swept          = rdata;
    swept.state    = olt_pkg::ST_FAILED;
    swept.last_upd = now;
  end

  function automatic logic move_ok(input logic [2:0] cur, input logic [2:0] tgt);
    logic ok;
    ok = 1'b0;
    unique case (tgt)
      olt_pkg::ST_EVPROC:  ok = (cur == olt_pkg::ST_EVQ);
      olt_pkg::ST_OCRQ:    ok = (cur == olt_pkg::ST_EVPROC);
      olt_pkg::ST_OCRPROC: ok = (cur == olt_pkg::ST_OCRQ);
      olt_pkg::ST_FINAL:   ok = (cur == olt_pkg::ST_OCRPROC);
      olt_pkg::ST_DONE:    ok = (cur == olt_pkg::ST_FINAL);
      olt_pkg::ST_FAILED:  ok = (cur != olt_pkg::ST_DONE) && (cur != olt_pkg::ST_FAILED);
      olt_pkg::ST_DUP:     ok = (cur == olt_pkg::ST_EVQ);
      default:             ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic olt_pkg::out_t mk_out(input logic [3:0] code, input logic fnd,
                                           input rec_t r, input logic [6:0] tc);
    olt_pkg::out_t o;
    o = '0;
    o.code          = code;
    o.tracked_count = tc;
    o.last          = 1'b1;
    if (fnd) begin
      o.entry_state    = r.state;
      o.entry_found    = 1'b1;
      o.bound_event_id = r.eid;
      o.event_bound    = r.bound;
      o.dup_count      = r.dups;
    end
    return o;
  endfunction

  // Outcome of a single-result item once the scan is over.
  olt_pkg::out_t act_out;
  logic          act_we, act_ins, act_seek;
  logic [IDXW-1:0] act_addr;
  rec_t          act_rec, new_rec;
  logic [6:0]    tc;

  always_comb begin
    tc       = 7'(count);
    act_we   = 1'b0;
    act_ins  = 1'b0;
    act_seek = 1'b0;
    act_addr = fslot;
    act_rec  = frec;
    new_rec            = '0;
    new_rec.key        = key;
    new_rec.state      = olt_pkg::ST_EVQ;
    new_rec.first_seen = now;
    new_rec.last_upd   = now;
    act_out  = mk_out(olt_pkg::CODE_INVALID, 1'b0, frec, tc);
    case (req.action)
      olt_pkg::ACT_OBSERVE: begin
        if (!req.is_plate) begin
          act_out = mk_out(olt_pkg::CODE_IGNORED, 1'b0, frec, tc);
        end else if (!req.fields_complete || now == '0) begin
          act_out = mk_out(olt_pkg::CODE_INVALID, 1'b0, frec, tc);
        end else if (found) begin
          act_we           = 1'b1;
          act_rec.last_upd = now;
          if (frec.dups != 32'hFFFF_FFFF) begin
            act_rec.dups = frec.dups + 32'd1;
          end
          act_out = mk_out(olt_pkg::CODE_DUPLICATE, 1'b1, act_rec, tc);
        end else if (8'(count) >= cap_e || !free_found) begin
          act_out = mk_out(olt_pkg::CODE_FULL, 1'b0, frec, tc);
        end else begin
          act_we   = 1'b1;
          act_ins  = 1'b1;
          act_addr = free_slot;
          act_rec  = new_rec;
          act_out  = mk_out(olt_pkg::CODE_QUEUED, 1'b1, new_rec, tc + 7'd1);
          act_out.new_object = 1'b1;
        end
      end
      olt_pkg::ACT_BIND: begin
        if (req.event_id_in[47]) begin
          act_out = mk_out(olt_pkg::CODE_REFUSED, found, frec, tc);
        end else if (!found) begin
          act_out = mk_out(olt_pkg::CODE_NOT_FOUND, 1'b0, frec, tc);
        end else if (frec.bound) begin
          act_out = mk_out((frec.eid == req.event_id_in[46:0]) ? olt_pkg::CODE_ACCEPTED
                           : olt_pkg::CODE_REFUSED, 1'b1, frec, tc);
        end else begin
          act_we        = 1'b1;
          act_rec.eid   = req.event_id_in[46:0];
          act_rec.bound = 1'b1;
          act_out = mk_out(olt_pkg::CODE_ACCEPTED, 1'b1, act_rec, tc);
        end
      end
      olt_pkg::ACT_MOVE: begin
        if (!found) begin
          act_out = mk_out(olt_pkg::CODE_NOT_FOUND, 1'b0, frec, tc);
        end else if (!move_ok(frec.state, req.target_state)) begin
          act_out = mk_out(olt_pkg::CODE_REFUSED, 1'b1, frec, tc);
        end else begin
          act_we        = 1'b1;
          act_rec.state = req.target_state;
          act_out = mk_out(olt_pkg::CODE_ACCEPTED, 1'b1, act_rec, tc);
        end
      end
      olt_pkg::ACT_SWEEP: begin
        act_seek = (hitmask != '0);
        act_out  = mk_out(olt_pkg::CODE_NONE_EXP, 1'b0, frec, tc);
      end
      olt_pkg::ACT_QUERY: begin
        act_out = mk_out(found ? olt_pkg::CODE_ACCEPTED : olt_pkg::CODE_NOT_FOUND,
                         found, frec, tc);
      end
      default: begin
        act_out = mk_out(olt_pkg::CODE_INVALID, 1'b0, frec, tc);
      end
    endcase
  end

  logic [TABLE_ENTRIES-1:0] cur_bit, hit_rest;
  olt_pkg::out_t            exp_out;
  logic                     out_load;

  always_comb begin
    cur_bit  = '0;
    cur_bit[cnt[IDXW-1:0]] = 1'b1;
    hit_rest = hitmask & ~cur_bit;
    exp_out  = mk_out(olt_pkg::CODE_EXPIRED, 1'b1, rdata, 7'(count));
    exp_out.expired_key = 64'(rdata.key);
    exp_out.last        = (hit_rest == '0);
  end

  assign out_load = ofree && (((st == S_ACT) && !act_seek) || (st == S_FETCH));

  always_comb begin
    we    = 1'b0;
    waddr = pidx;
    wdata = swept;
    if (st == S_SCAN && sweep_hit) begin
      we = 1'b1;
    end else if (st == S_ACT && ofree && act_we) begin
      we    = 1'b1;
      waddr = act_addr;
      wdata = act_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      cnt       <= '0;
      pv        <= 1'b0;
      vbits     <= '0;
      hitmask   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      ttl       <= 32'd30000;
      cap       <= 7'd64;
    end else begin
      if (cfg_write) begin
        if (cfg_index == olt_pkg::CFG_TTL) begin
          ttl <= cfg_data;
        end else begin
          cap <= cfg_data[6:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            cnt        <= '0;
            pv         <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            hitmask    <= '0;
            st         <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt < (IDXW+1)'(TABLE_ENTRIES)) begin
            pv   <= 1'b1;
            pidx <= cnt[IDXW-1:0];
            cnt  <= cnt + 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (purge_hit) begin
              vbits[pidx] <= 1'b0;
              count       <= count - 1'b1;
            end
            if (sweep_hit) begin
              hitmask[pidx] <= 1'b1;
            end
            if (key_hit && !found) begin
              found <= 1'b1;
              fslot <= pidx;
              frec  <= rdata;
            end
            if (!vpost && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= pidx;
            end
            if (pidx == IDXW'(TABLE_ENTRIES - 1)) begin
              st <= S_ACT;
            end
          end
        end
        S_ACT: begin
          if (ofree) begin
            if (act_seek) begin
              cnt <= '0;
              st  <= S_SEEK;
            end else begin
              out_data  <= act_out;
              if (act_ins) begin
                vbits[act_addr] <= 1'b1;
                count           <= count + 1'b1;
              end
              st <= S_IDLE;
            end
          end
        end
        S_SEEK: begin
          if (cnt >= (IDXW+1)'(TABLE_ENTRIES)) begin
            st <= S_IDLE;
          end else if (hitmask[cnt[IDXW-1:0]]) begin
            st <= S_FETCH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FETCH: begin
          // Read data for the slot under cnt is held while the output is busy.
          if (ofree) begin
            out_data  <= exp_out;
            hitmask   <= hit_rest;
            cnt       <= cnt + 1'b1;
            st        <= (hit_rest == '0) ? S_IDLE : S_SEEK;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/olt_rec_mem.sv =====
// ----------------------------------------------------------------------------
// Entry record memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module olt_rec_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int W     = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/olt_checker.sv =====
// ----------------------------------------------------------------------------
// Object lifecycle table port checker
// Concurrent checks on the result beats seen at the top-level ports.
// ----------------------------------------------------------------------------
module olt_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_stall,
  input olt_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_expired: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.code == olt_pkg::CODE_EXPIRED |->
      out_data.entry_found && out_data.entry_state == olt_pkg::ST_FAILED)
    else $error("expired beat does not show a failed entry");

  a_newobj: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.new_object |->
      out_data.code == olt_pkg::CODE_QUEUED && out_data.entry_state == olt_pkg::ST_EVQ)
    else $error("new object flagged on a beat that is not an insertion");

  a_notfound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_found |->
      out_data.dup_count == 32'd0 && !out_data.event_bound)
    else $error("entry contents shown without an entry");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> out_data.code == olt_pkg::CODE_EXPIRED)
    else $error("only sweep may give more than one beat");

endmodule

bind object_lifecycle_table_with_ttl olt_checker u_olt_checker (.*);
